@@ rtl/krt_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and width helpers for the keyed record table.
// Used by krt_ram, krt_engine and keyed_record_table_top; depends on nothing.
package krt_pkg;

    // Default number of records the table can hold
    localparam int CAPACITY_DEF = 256;

    // Request kinds
    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_SEARCH = 2'd1;
    localparam logic [1:0] REQ_UPDATE = 2'd2;
    localparam logic [1:0] REQ_DELETE = 2'd3;

    // Status codes
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_EXISTS  = 2'd2;
    localparam logic [1:0] ST_MISSING = 2'd3;

    // Request word
    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] key;
        logic [7:0]         age_in;
        logic [31:0]        marks_in;
    } t_req_s;

    // Response word
    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  age_out;
        logic [31:0] marks_out;
        logic [8:0]  entries_held;
    } t_rsp_s;

    // One stored record
    typedef struct packed {
        logic [31:0] key;
        logic [7:0]  age;
        logic [31:0] marks;
    } t_rec_s;

    localparam int REC_W = $bits(t_rec_s);

    // Address bits for a memory of n entries (at least one)
    function automatic int addr_w(input int n);
        addr_w = (n > 1) ? $clog2(n) : 1;
    endfunction

    // Bits for a count that runs 0..n
    function automatic int cnt_w(input int n);
        cnt_w = $clog2(n + 1);
    endfunction

endpackage

@@ rtl/krt_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Depends on krt_pkg for the address width helper and defaults.
module krt_ram #(
    parameter int WIDTH = krt_pkg::REC_W,
    parameter int DEPTH = krt_pkg::CAPACITY_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_wr_en,
    input  logic [krt_pkg::addr_w(DEPTH)-1:0]   i_wr_addr,
    input  logic [WIDTH-1:0]                    i_wr_data,
    input  logic                                i_rd_en,
    input  logic [krt_pkg::addr_w(DEPTH)-1:0]   i_rd_addr,
    output logic [WIDTH-1:0]                    o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/krt_engine.sv @@
`timescale 1ns / 1ps
// Request sequencer: linear key search, add/update writes and the
// compacting shift on delete, all through one RAM port pair and one comparator.
// Depends on krt_pkg.
module krt_engine #(
    parameter int CAPACITY = krt_pkg::CAPACITY_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // request side
    input  logic                                  i_req_valid,
    input  krt_pkg::t_req_s                       i_req,
    output logic                                  o_req_stall,
    // result side
    output logic                                  o_res_valid,
    input  logic                                  i_res_ready,
    output krt_pkg::t_rsp_s                       o_res,
    // table RAM
    output logic                                  o_rd_en,
    output logic [krt_pkg::addr_w(CAPACITY)-1:0]  o_rd_addr,
    input  logic [krt_pkg::REC_W-1:0]             i_rd_data,
    output logic                                  o_wr_en,
    output logic [krt_pkg::addr_w(CAPACITY)-1:0]  o_wr_addr,
    output logic [krt_pkg::REC_W-1:0]             o_wr_data
);

    localparam int AW = krt_pkg::addr_w(CAPACITY);
    localparam int CW = krt_pkg::cnt_w(CAPACITY);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_SHIFT  = 2'd2;
    localparam logic [1:0] S_DONE   = 2'd3;

    logic [1:0]      r_state, n_state;
    logic [CW-1:0]   r_count, n_count;   // records held
    logic [CW-1:0]   r_idx,   n_idx;     // next address to read
    logic [CW-1:0]   r_cidx,  n_cidx;    // address of the data now on the read port
    logic            r_pend,  n_pend;    // read data valid this cycle
    krt_pkg::t_req_s r_req,   n_req;
    logic [1:0]      r_status, n_status;
    logic [7:0]      r_age,    n_age;
    logic [31:0]     r_marks,  n_marks;

    krt_pkg::t_rec_s rec_q;
    krt_pkg::t_rec_s rec_new;
    logic            hit;
    logic [CW-1:0]   cidx_m1;

    assign rec_q   = krt_pkg::t_rec_s'(i_rd_data);
    assign cidx_m1 = r_cidx - CW'(1);

    // shared key comparator
    assign hit = r_pend && (rec_q.key == r_req.key);

    assign o_rd_addr   = r_idx[AW-1:0];
    assign o_req_stall = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_DONE);

    always_comb begin
        o_res.status       = r_status;
        o_res.age_out      = r_age;
        o_res.marks_out    = r_marks;
        o_res.entries_held = 9'(r_count);
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_cidx   = r_cidx;
        n_pend   = r_pend;
        n_req    = r_req;
        n_status = r_status;
        n_age    = r_age;
        n_marks  = r_marks;
        o_rd_en  = 1'b0;
        o_wr_en  = 1'b0;
        o_wr_addr = '0;
        rec_new.key   = r_req.key;
        rec_new.age   = r_req.age_in;
        rec_new.marks = r_req.marks_in;
        o_wr_data = rec_new;

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_req   = i_req;
                    n_idx   = '0;
                    n_pend  = 1'b0;
                    n_state = S_SEARCH;
                end
            end

            S_SEARCH: begin
                if (hit || (r_idx == r_count)) begin
                    // search resolved: found at r_cidx, or not present
                    n_pend   = 1'b0;
                    n_status = krt_pkg::ST_DONE;
                    n_age    = '0;
                    n_marks  = '0;
                    n_state  = S_DONE;
                    unique case (r_req.req_type)
                        krt_pkg::REQ_ADD: begin
                            if (r_count == CW'(CAPACITY)) begin
                                n_status = krt_pkg::ST_FULL;
                            end else if (hit) begin
                                n_status = krt_pkg::ST_EXISTS;
                            end else begin
                                o_wr_en   = 1'b1;
                                o_wr_addr = r_count[AW-1:0];
                                n_count   = r_count + CW'(1);
                            end
                        end
                        krt_pkg::REQ_SEARCH: begin
                            if (hit) begin
                                n_age   = rec_q.age;
                                n_marks = rec_q.marks;
                            end else begin
                                n_status = krt_pkg::ST_MISSING;
                            end
                        end
                        krt_pkg::REQ_UPDATE: begin
                            if (hit) begin
                                o_wr_en   = 1'b1;
                                o_wr_addr = r_cidx[AW-1:0];
                            end else begin
                                n_status = krt_pkg::ST_MISSING;
                            end
                        end
                        krt_pkg::REQ_DELETE: begin
                            if (hit) begin
                                n_idx   = r_cidx + CW'(1);
                                n_state = S_SHIFT;
                            end else begin
                                n_status = krt_pkg::ST_MISSING;
                            end
                        end
                        default: n_status = krt_pkg::ST_MISSING;
                    endcase
                end else begin
                    // fetch next record
                    o_rd_en = 1'b1;
                    n_pend  = 1'b1;
                    n_cidx  = r_idx;
                    n_idx   = r_idx + CW'(1);
                end
            end

            S_SHIFT: begin
                // move the record just read one place down
                if (r_pend) begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = cidx_m1[AW-1:0];
                    o_wr_data = i_rd_data;
                end
                if (r_idx < r_count) begin
                    o_rd_en = 1'b1;
                    n_pend  = 1'b1;
                    n_cidx  = r_idx;
                    n_idx   = r_idx + CW'(1);
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_count = r_count - CW'(1);
                        n_state = S_DONE;
                    end
                end
            end

            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_cidx   <= n_cidx;
        r_req    <= n_req;
        r_status <= n_status;
        r_age    <= n_age;
        r_marks  <= n_marks;
    end

endmodule

@@ rtl/keyed_record_table_top.sv @@
`timescale 1ns / 1ps
// Top level of the keyed record table: table RAM, request sequencer and
// output register. Depends on krt_pkg, krt_ram and krt_engine.
//
// Usage:
//   Input channel i_in_valid / o_in_stall carries one request word
//   (add, search, update or delete with key, age and marks). Output channel
//   o_out_valid / i_out_stall carries exactly one response word per request:
//   status, age and marks (search hits only) and the entry count after it.
//   The search reads one record per cycle and the delete shift moves one
//   record per cycle. The response follows once the search resolves, and
//   for a delete hit once the shift has moved every later record down.
//   o_in_stall is high while a request runs and drops as the response
//   moves to the output register, so no new request is taken before then.
//   If the receiver stalls, the next request is still taken while an earlier
//   response waits; the response after that holds inside the sequencer
//   until the register frees, and the input stays stalled meanwhile.
//   Reset (synchronous, active low) empties the table at once; no RAM
//   clearing pass is needed since only entries below the count are read.
module keyed_record_table_top #(
    parameter int CAPACITY = krt_pkg::CAPACITY_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  krt_pkg::t_req_s i_in,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output krt_pkg::t_rsp_s o_out
);

    localparam int AW = krt_pkg::addr_w(CAPACITY);

    logic                      rd_en;
    logic [AW-1:0]             rd_addr;
    logic [krt_pkg::REC_W-1:0] rd_data;
    logic                      wr_en;
    logic [AW-1:0]             wr_addr;
    logic [krt_pkg::REC_W-1:0] wr_data;
    logic                      res_valid;
    logic                      res_ready;
    krt_pkg::t_rsp_s           res;

    logic            r_out_valid;
    krt_pkg::t_rsp_s r_out;

    krt_ram #(
        .WIDTH (krt_pkg::REC_W),
        .DEPTH (CAPACITY)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    krt_engine #(
        .CAPACITY (CAPACITY)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_in_valid),
        .i_req       (i_in),
        .o_req_stall (o_in_stall),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data)
    );

    // output register takes a new word when empty or being drained
    assign res_ready = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
